[hw/rtl/tlrq_pkg.sv]
// Types and codes shared by the three-level ready queue and its testbench-free
// RTL. No dependencies.
`timescale 1ns / 1ps

package tlrq_pkg;

  // operation codes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // internal level codes (memory region select); reported level is code + 1
  localparam logic [1:0] LC_TIME = 2'd0;
  localparam logic [1:0] LC_PRIO = 2'd1;
  localparam logic [1:0] LC_FIFO = 2'd2;

  // queue_level field values that select a sorted level
  localparam logic [1:0] QL_TIME = 2'd1;
  localparam logic [1:0] QL_PRIO = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [7:0]  task_id;
    logic [1:0]  queue_level;
    logic [15:0] sort_key;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] chosen_task;
    logic [1:0] chosen_level;
  } rsp_item_t;

endpackage

[hw/rtl/tlrq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/three_level_ready_queue.sv]
// Three-level ready queue: top level with sequencer, level pointers and the
// result register. Uses tlrq_pkg and one tlrq_ram instance for all entries.
`timescale 1ns / 1ps

//  channel | valid     | stall     | payload                | direction
//  --------+-----------+-----------+------------------------+----------
//  request | req_valid | req_stall | req (req_item_t)       | in
//  result  | rsp_valid | rsp_stall | rsp (rsp_item_t)       | out
//
// Sequence: an item is accepted in S_IDLE, then worked, then its result is
//   loaded from S_RESULT. FIFO enqueue, full drop, empty dequeue, enqueue into
//   an empty sorted level go straight to S_RESULT. Dequeue passes S_DEQ.
//   Sorted enqueue into a non-empty level walks S_SHIFT over k entries that move
//   (at most the level's count), then S_PLACE if all of them move; the walk is set
//   by the single read port of the entry RAM (one entry per cycle).
// Reset clears counts, head pointers, the sequencer and the result valid flag;
//   the entry RAM is not cleared (only entries inside a level are ever read).
// One item is in work at a time; the next item is taken while the previous
//   result still waits in the output register under rsp_stall.

module three_level_ready_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_WIDTH   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  tlrq_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tlrq_pkg::rsp_item_t rsp
);

  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W     = IDX_W + 1;
  localparam int ADDR_W    = IDX_W + 2;
  localparam int MEM_DEPTH = 3 << IDX_W;
  localparam int ENT_W     = 8 + KEY_WIDTH;
  localparam int KEY_EXT_W = (KEY_WIDTH > 16) ? KEY_WIDTH : 16;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_PLACE  = 3'd2;
  localparam logic [2:0] S_DEQ    = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  // circular index helpers
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : i - 1'b1;
  endfunction

  logic [2:0]       state;
  logic [IDX_W-1:0] head  [3];
  logic [CNT_W-1:0] count [3];
  logic [1:0]       lc_q;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] remain;
  logic [7:0]       new_id;
  logic [KEY_WIDTH-1:0] new_key;
  tlrq_pkg::rsp_item_t  res;

  // decode of the incoming item
  logic                 accept;
  logic [1:0]           idle_lc;
  logic [1:0]           sel_lc;
  logic [CNT_W-1:0]     cnt_s;
  logic [IDX_W-1:0]     head_s;
  logic [SUM_W-1:0]     tail_sum;
  logic [IDX_W-1:0]     tail_s;
  logic [KEY_EXT_W-1:0] key_ext;
  logic [KEY_WIDTH-1:0] key_in;
  logic                 all_empty;
  logic                 lvl_full;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  // insertion compare
  logic [7:0]           rd_id;
  logic [KEY_WIDTH-1:0] rd_key;
  logic                 moves_back;
  logic [CNT_W-1:0]     remain_dec;
  logic                 rsp_load;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);

  assign all_empty = (count[0] == '0) && (count[1] == '0) && (count[2] == '0);

  always_comb begin
    if (req.operation == tlrq_pkg::OP_ENQUEUE) begin
      if (req.queue_level == tlrq_pkg::QL_TIME) begin
        idle_lc = tlrq_pkg::LC_TIME;
      end else if (req.queue_level == tlrq_pkg::QL_PRIO) begin
        idle_lc = tlrq_pkg::LC_PRIO;
      end else begin
        idle_lc = tlrq_pkg::LC_FIFO;
      end
    end else begin
      if (count[0] != '0) begin
        idle_lc = tlrq_pkg::LC_TIME;
      end else if (count[1] != '0) begin
        idle_lc = tlrq_pkg::LC_PRIO;
      end else begin
        idle_lc = tlrq_pkg::LC_FIFO;
      end
    end
  end

  assign sel_lc   = (state == S_IDLE) ? idle_lc : lc_q;
  assign cnt_s    = count[sel_lc];
  assign head_s   = head[sel_lc];
  assign tail_sum = SUM_W'(head_s) + SUM_W'(cnt_s);
  assign tail_s   = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
  assign lvl_full = (cnt_s == CNT_W'(QUEUE_DEPTH));

  // only the low KEY_WIDTH bits of the key take part
  assign key_ext = KEY_EXT_W'(req.sort_key);
  assign key_in  = key_ext[KEY_WIDTH-1:0];

  assign rd_id      = ram_rdata[ENT_W-1:KEY_WIDTH];
  assign rd_key     = ram_rdata[KEY_WIDTH-1:0];
  // a stored entry moves back when the new key must go ahead of it;
  // equal keys never move, so ties leave in arrival order
  assign moves_back = (lc_q == tlrq_pkg::LC_PRIO) ? (rd_key < new_key) : (rd_key > new_key);
  assign remain_dec = remain - 1'b1;

  assign rsp_load = (state == S_RESULT) && (!rsp_valid || !rsp_stall);

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.operation == tlrq_pkg::OP_ENQUEUE) begin
            if (!lvl_full && (idle_lc == tlrq_pkg::LC_FIFO || cnt_s == '0)) begin
              ram_we    = 1'b1;
              ram_waddr = {idle_lc, tail_s};
              ram_wdata = {req.task_id, key_in};
            end else if (!lvl_full) begin
              ram_re    = 1'b1;
              ram_raddr = {idle_lc, idx_dec(tail_s)};
            end
          end else if (!all_empty) begin
            ram_re    = 1'b1;
            ram_raddr = {idle_lc, head_s};
          end
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = {lc_q, idx_inc(slot)};
        ram_wdata = moves_back ? ram_rdata : {new_id, new_key};
        if (moves_back && remain_dec != '0) begin
          ram_re    = 1'b1;
          ram_raddr = {lc_q, idx_dec(slot)};
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = {lc_q, slot};
        ram_wdata = {new_id, new_key};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer, level pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int l = 0; l < 3; l++) begin
        head[l]  <= '0;
        count[l] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.operation == tlrq_pkg::OP_ENQUEUE) begin
              if (lvl_full) begin
                // drop: level holds QUEUE_DEPTH tasks
                res   <= '{status: tlrq_pkg::ST_FULL, chosen_task: '0, chosen_level: '0};
                state <= S_RESULT;
              end else if (idle_lc == tlrq_pkg::LC_FIFO || cnt_s == '0) begin
                count[sel_lc] <= cnt_s + 1'b1;
                res   <= '{status: tlrq_pkg::ST_DONE, chosen_task: '0, chosen_level: '0};
                state <= S_RESULT;
              end else begin
                // walk from the tail toward the head, one entry per cycle
                slot   <= idx_dec(tail_s);
                remain <= cnt_s;
                state  <= S_SHIFT;
              end
            end else if (all_empty) begin
              res   <= '{status: tlrq_pkg::ST_EMPTY, chosen_task: '0, chosen_level: '0};
              state <= S_RESULT;
            end else begin
              head[sel_lc]  <= idx_inc(head_s);
              count[sel_lc] <= cnt_s - 1'b1;
              state         <= S_DEQ;
            end
            lc_q    <= idle_lc;
            new_id  <= req.task_id;
            new_key <= key_in;
          end
        end
        S_SHIFT: begin
          if (moves_back) begin
            if (remain_dec == '0) begin
              state <= S_PLACE;
            end else begin
              slot   <= idx_dec(slot);
              remain <= remain_dec;
            end
          end else begin
            count[sel_lc] <= cnt_s + 1'b1;
            res   <= '{status: tlrq_pkg::ST_DONE, chosen_task: '0, chosen_level: '0};
            state <= S_RESULT;
          end
        end
        S_PLACE: begin
          count[sel_lc] <= cnt_s + 1'b1;
          res   <= '{status: tlrq_pkg::ST_DONE, chosen_task: '0, chosen_level: '0};
          state <= S_RESULT;
        end
        S_DEQ: begin
          res   <= '{status: tlrq_pkg::ST_DONE, chosen_task: rd_id,
                     chosen_level: lc_q + 2'd1};
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register: hold under stall, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  tlrq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MEM_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count[0] <= CNT_W'(QUEUE_DEPTH) && count[1] <= CNT_W'(QUEUE_DEPTH) &&
    count[2] <= CNT_W'(QUEUE_DEPTH))
    else $error("level count beyond queue depth");

  a_shift_remain: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> remain != '0 && lc_q != tlrq_pkg::LC_FIFO)
    else $error("insertion walk past the head or on the FIFO level");

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESULT))
    else $error("result shown without a finished item");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != tlrq_pkg::ST_DONE |->
      rsp.chosen_task == '0 && rsp.chosen_level == '0)
    else $error("failed item carries a task");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for three_level_ready_queue: directed table, then random traffic.
// Depends on tlrq_pkg and the three_level_ready_queue RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1500;
  // Worst item: sorted insert moving every other entry of its level.
  localparam int DRAIN_CYCLES = 40;
  // Slowest run stays far below this, even with long gaps and stalls.
  localparam int CYCLE_LIMIT  = 400000;

  // Reported levels besides the two sorted ones.
  localparam logic [1:0] LEVEL_NONE = 2'd0;
  localparam logic [1:0] LEVEL_FIFO = 2'd3;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] key;
  } ready_entry_t;

  // One line of the directed table. Copies repeat the item with task_id
  // advancing by one; a known row carries its status typed in.
  typedef struct packed {
    tlrq_pkg::req_item_t item;
    logic [6:0]          copies;
    logic                known;
    tlrq_pkg::rsp_item_t answer;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  tlrq_pkg::req_item_t req;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  tlrq_pkg::rsp_item_t rsp;

  // Mirror of the three levels, front entry at index 0.
  ready_entry_t time_level[$];
  ready_entry_t prio_level[$];
  logic [7:0]   fifo_level[$];

  tlrq_pkg::rsp_item_t awaited[$];  // results still owed by the block, oldest first
  stim_row_t           plan[$];
  logic                quiet;       // hold both sides busy, no idling at all
  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  tlrq_pkg::rsp_item_t want;

  three_level_ready_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KEY_WIDTH  (16)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted item to the mirrored levels and return the result
  // the block owes for it.
  function automatic tlrq_pkg::rsp_item_t schedule_step(tlrq_pkg::req_item_t it);
    tlrq_pkg::rsp_item_t res;
    ready_entry_t        ent;
    int                  slot;
    res = '0;
    res.status = tlrq_pkg::ST_DONE;
    res.chosen_level = LEVEL_NONE;
    ent.id  = it.task_id;
    ent.key = it.sort_key;
    if (it.operation == tlrq_pkg::OP_ENQUEUE) begin
      if (it.queue_level == tlrq_pkg::QL_TIME) begin
        if (time_level.size() >= QUEUE_DEPTH) begin
          res.status = tlrq_pkg::ST_FULL;
        end else begin
          // Ascending; go behind every entry with an equal key.
          slot = 0;
          while (slot < time_level.size() && time_level[slot].key <= ent.key) slot++;
          time_level.insert(slot, ent);
        end
      end else if (it.queue_level == tlrq_pkg::QL_PRIO) begin
        if (prio_level.size() >= QUEUE_DEPTH) begin
          res.status = tlrq_pkg::ST_FULL;
        end else begin
          // Descending; equal keys keep arrival order.
          slot = 0;
          while (slot < prio_level.size() && prio_level[slot].key >= ent.key) slot++;
          prio_level.insert(slot, ent);
        end
      end else begin
        // Level 0 and level 3 both land in the FIFO.
        if (fifo_level.size() >= QUEUE_DEPTH) res.status = tlrq_pkg::ST_FULL;
        else fifo_level.push_back(it.task_id);
      end
    end else begin
      if (time_level.size() > 0) begin
        ent = time_level.pop_front();
        res.chosen_task  = ent.id;
        res.chosen_level = tlrq_pkg::QL_TIME;
      end else if (prio_level.size() > 0) begin
        ent = prio_level.pop_front();
        res.chosen_task  = ent.id;
        res.chosen_level = tlrq_pkg::QL_PRIO;
      end else if (fifo_level.size() > 0) begin
        res.chosen_task  = fifo_level.pop_front();
        res.chosen_level = LEVEL_FIFO;
      end else begin
        res.status = tlrq_pkg::ST_EMPTY;
      end
    end
    return res;
  endfunction

  function automatic void add_row(logic op, logic [7:0] id, logic [1:0] lvl,
                                  logic [15:0] key, int copies, bit known,
                                  logic [1:0] st);
    stim_row_t row;
    row = '0;
    row.item.operation   = op;
    row.item.task_id     = id;
    row.item.queue_level = lvl;
    row.item.sort_key    = key;
    row.copies           = 7'(copies);
    row.known            = known;
    row.answer.status    = st;
    plan.push_back(row);
  endfunction

  // Random item; enq_pct sets how often it enqueues, which steers the
  // levels toward full or toward empty.
  function automatic tlrq_pkg::req_item_t random_item(int enq_pct);
    tlrq_pkg::req_item_t it;
    it.operation   = ($urandom_range(99) < enq_pct) ? tlrq_pkg::OP_ENQUEUE :
                                                      tlrq_pkg::OP_DEQUEUE;
    it.task_id     = 8'($urandom_range(255));
    it.queue_level = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: it.sort_key = 16'($urandom_range(3));               // crowd keys into ties
      1: it.sort_key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: it.sort_key = 16'($urandom_range(16'hFFFF));
    endcase
    return it;
  endfunction

  // Offer one item and hold it until the block takes it. Record what the
  // block owes for it at the accepting edge. Idle the request side at random
  // first, scribbling over the payload while valid is low.
  task automatic send_item(input tlrq_pkg::req_item_t it, input bit known,
                           input tlrq_pkg::rsp_item_t answer);
    tlrq_pkg::rsp_item_t guess;
    if (!quiet && $urandom_range(99) < 31) begin
      req_valid <= 1'b0;
      req       <= tlrq_pkg::req_item_t'($urandom);
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (req_stall);
    guess = schedule_step(it);
    awaited.push_back(known ? answer : guess);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic pause_until_drained();
    req_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Stall the result side at random, 31 percent of the time, except in the quiet stretch.
  always @(posedge clk) begin
    if (quiet) rsp_stall <= 1'b0;
    else rsp_stall <= ($urandom_range(99) < 31);
  end

  // Check every accepted result against the oldest owed one, field by field.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited.size() == 0) begin
        $error("status: expected no result, got %0d (chosen_task %0d, chosen_level %0d)",
               rsp.status, rsp.chosen_task, rsp.chosen_level);
        mismatch_count++;
      end else begin
        want = awaited.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.chosen_task !== want.chosen_task) begin
          $error("chosen_task: expected %0d, got %0d", want.chosen_task, rsp.chosen_task);
          mismatch_count++;
        end
        if (rsp.chosen_level !== want.chosen_level) begin
          $error("chosen_level: expected %0d, got %0d", want.chosen_level, rsp.chosen_level);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    tlrq_pkg::req_item_t it;
    stim_row_t           row;
    int                  enq_pct;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    quiet     = 1'b0;

    // Directed table. Dequeue rows carry junk in the fields they ignore.
    add_row(tlrq_pkg::OP_DEQUEUE, 8'hFF, tlrq_pkg::QL_PRIO, 16'hFFFF, 1, 1,
            tlrq_pkg::ST_EMPTY);                                   // empty after reset
    add_row(tlrq_pkg::OP_ENQUEUE, 8'h00, tlrq_pkg::QL_TIME, 16'hFFFF, 1, 1,
            tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'hFF, tlrq_pkg::QL_TIME, 16'h0000, 1, 1,
            tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'h11, tlrq_pkg::QL_TIME, 16'h0000, 1, 1,
            tlrq_pkg::ST_DONE);                                    // tie goes behind
    add_row(tlrq_pkg::OP_ENQUEUE, 8'h22, tlrq_pkg::QL_PRIO, 16'h0000, 1, 1,
            tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'h33, tlrq_pkg::QL_PRIO, 16'hFFFF, 1, 1,
            tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'h44, tlrq_pkg::QL_PRIO, 16'hFFFF, 1, 1,
            tlrq_pkg::ST_DONE);                                    // tie goes behind
    add_row(tlrq_pkg::OP_ENQUEUE, 8'h55, LEVEL_FIFO, 16'h1234, 1, 1, tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'hAA, LEVEL_NONE, 16'hFFFF, 1, 1,
            tlrq_pkg::ST_DONE);                                    // level 0 joins FIFO
    add_row(tlrq_pkg::OP_DEQUEUE, 8'h5A, LEVEL_FIFO, 16'hA5A5, 9, 0, tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_DEQUEUE, 8'h00, LEVEL_NONE, 16'h0000, 1, 1, tlrq_pkg::ST_EMPTY);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'h60, LEVEL_FIFO, 16'h0000, 16, 1, tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'h7F, LEVEL_NONE, 16'h0000, 1, 1,
            tlrq_pkg::ST_FULL);                                    // FIFO full
    add_row(tlrq_pkg::OP_ENQUEUE, 8'h80, tlrq_pkg::QL_TIME, 16'h0100, 8, 1,
            tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'h90, tlrq_pkg::QL_TIME, 16'h00FF, 8, 1,
            tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'hEE, tlrq_pkg::QL_TIME, 16'h0000, 1, 1,
            tlrq_pkg::ST_FULL);                                    // time level full
    add_row(tlrq_pkg::OP_ENQUEUE, 8'hA0, tlrq_pkg::QL_PRIO, 16'h8000, 15, 1,
            tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'hC0, tlrq_pkg::QL_PRIO, 16'hFFFF, 1, 1,
            tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_ENQUEUE, 8'hDD, tlrq_pkg::QL_PRIO, 16'hFFFF, 1, 1,
            tlrq_pkg::ST_FULL);                                    // priority level full
    add_row(tlrq_pkg::OP_DEQUEUE, 8'hFF, tlrq_pkg::QL_TIME, 16'hFFFF, 48, 0,
            tlrq_pkg::ST_DONE);
    add_row(tlrq_pkg::OP_DEQUEUE, 8'hFF, tlrq_pkg::QL_TIME, 16'hFFFF, 1, 1,
            tlrq_pkg::ST_EMPTY);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      row = plan[r];
      for (int k = 0; k < row.copies; k++) begin
        it = row.item;
        it.task_id = 8'(row.item.task_id + k);
        send_item(it, row.known, row.answer);
      end
    end
    pause_until_drained();

    // Random traffic in phases: fill, drain or balanced, so the levels swing
    // between full and empty with plenty of ties along the way.
    enq_pct = 55;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 80;
          1: enq_pct = 25;
          default: enq_pct = 55;
        endcase
      end
      if (n == 600) quiet <= 1'b1;
      if (n == 800) quiet <= 1'b0;
      if (n == 400 || n == 1200) pause_until_drained();
      send_item(random_item(enq_pct), 1'b0, '0);
    end

    // Let the last result land, then give the block time to show a stray one.
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
